// ----- hw/rtl/grum_pkg.sv -----
// Shared types and constants of the grid region union merge block.
`default_nettype none

package grum_pkg;

    localparam int DIM_W     = 7;
    localparam int ROW_W     = 6;
    localparam int CNT_W     = 2 * DIM_W;
    localparam int OUT_CNT_W = 13;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd7;
    localparam logic [DIM_W-1:0] DIM_MIN   = 7'd2;

    localparam logic ACT_CLEAR = 1'b0;
    localparam logic DIR_RIGHT = 1'b0;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_WIPE,
        ST_RD_A,
        ST_RD_B,
        ST_CMP,
        ST_WALK,
        ST_WALK_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic idx_clr;
        logic wipe_step;
        logic count_init;
        logic flags_init;
        logic rd_a;
        logic rd_b;
        logic lat_a;
        logic lat_b;
        logic merge;
        logic walk_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic bad;
        logic same;
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/grum_ctrl.sv -----
// Controller state machine that sequences clearing passes, label reads and merges.
`default_nettype none

module grum_ctrl
    import grum_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire logic    cfg_we,
    input  wire status_t status_i,
    output cmd_t         cmd_o
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (status_i.idx_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (cfg_we) begin
                    state_next = ST_INIT;
                end else if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status_i.is_clear) begin
                    state_next = ST_WIPE;
                end else if (status_i.bad) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_RD_A;
                end
            end
            ST_WIPE: begin
                if (status_i.idx_last) state_next = ST_DONE;
            end
            ST_RD_A:     state_next = ST_RD_B;
            ST_RD_B:     state_next = ST_CMP;
            ST_CMP: begin
                if (status_i.same) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (status_i.idx_last) state_next = ST_WALK_END;
            end
            ST_WALK_END: state_next = ST_DONE;
            ST_DONE: begin
                if (status_i.out_free) state_next = ST_IDLE;
            end
            default:     state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd_o   = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd_o.wipe_step = 1'b1;
            end
            ST_IDLE: begin
                s_ready        = !cfg_we;
                cmd_o.idx_clr  = 1'b1;
                cmd_o.capture  = s_valid && !cfg_we;
            end
            ST_CHECK: begin
                cmd_o.flags_init = 1'b1;
                cmd_o.count_init = status_i.is_clear;
            end
            ST_WIPE: begin
                cmd_o.wipe_step = 1'b1;
            end
            ST_RD_A: begin
                cmd_o.rd_a = 1'b1;
            end
            ST_RD_B: begin
                cmd_o.rd_b  = 1'b1;
                cmd_o.lat_a = 1'b1;
            end
            ST_CMP: begin
                cmd_o.lat_b = 1'b1;
                cmd_o.merge = !status_i.same;
            end
            ST_WALK: begin
                cmd_o.walk_rd = 1'b1;
            end
            ST_WALK_END: begin
                cmd_o = '0;
            end
            ST_DONE: begin
                cmd_o.out_load = status_i.out_free;
            end
            default: begin
                cmd_o = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/grum_dp.sv -----
// Datapath with the cell label memory, region count, request fields and result register.
`default_nettype none

module grum_dp
    import grum_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_action,
    input  wire logic [ROW_W-1:0]     s_cell_row,
    input  wire logic [ROW_W-1:0]     s_cell_col,
    input  wire logic                 s_direction,
    input  wire logic                 cfg_we,
    input  wire logic [DIM_W-1:0]     cfg_wdata,
    input  wire cmd_t                 cmd_i,
    output status_t                   status_o,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_wall_removed,
    output logic [OUT_CNT_W-1:0]      m_regions_left,
    output logic                      m_all_joined,
    output logic                      m_bad_wall
);

    localparam int CELLS   = MAX_SIDE * MAX_SIDE;
    localparam int AW      = $clog2(CELLS);
    localparam int MAX_DIM = (MAX_SIDE > 127) ? 127 : MAX_SIDE;
    localparam int RST_DIM = (int'(DIM_RESET) > MAX_DIM) ? MAX_DIM : int'(DIM_RESET);
    localparam int RST_CNT = RST_DIM * RST_DIM;

    logic [AW-1:0]        mem [CELLS];
    logic [AW-1:0]        rdata_reg;
    logic [AW-1:0]        raddr;

    logic                 action_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     col_reg;
    logic                 dir_reg;

    logic [DIM_W-1:0]     dim_reg;
    logic [DIM_W-1:0]     dim_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     dim_sq;
    logic [CNT_W-1:0]     cfg_sq;

    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        la_reg;
    logic [AW-1:0]        lb_reg;
    logic                 pipe_v_reg;
    logic [AW-1:0]        pipe_addr_reg;
    logic                 wb_en;

    logic                 removed_reg;
    logic                 bad_reg;
    logic                 m_valid_reg;

    logic [DIM_W-1:0]     nrow;
    logic [DIM_W-1:0]     ncol;
    logic [DIM_W-1:0]     row_ext;
    logic [DIM_W-1:0]     col_ext;
    logic                 bad_comb;
    logic [AW-1:0]        ia;
    logic [AW-1:0]        ib;

    // Dimension writes are saturated into the supported range.
    always_comb begin
        if (cfg_wdata < DIM_MIN) begin
            dim_next = DIM_MIN;
        end else if (int'(cfg_wdata) > MAX_DIM) begin
            dim_next = DIM_W'(MAX_DIM);
        end else begin
            dim_next = cfg_wdata;
        end
    end

    assign dim_sq = {{(CNT_W-DIM_W){1'b0}}, dim_reg} * {{(CNT_W-DIM_W){1'b0}}, dim_reg};
    assign cfg_sq = {{(CNT_W-DIM_W){1'b0}}, dim_next} * {{(CNT_W-DIM_W){1'b0}}, dim_next};

    assign row_ext  = {1'b0, row_reg};
    assign col_ext  = {1'b0, col_reg};
    assign nrow     = row_ext + ((dir_reg != DIR_RIGHT) ? 7'd1 : 7'd0);
    assign ncol     = col_ext + ((dir_reg == DIR_RIGHT) ? 7'd1 : 7'd0);
    assign bad_comb = (row_ext >= dim_reg) || (col_ext >= dim_reg) ||
                      (nrow >= dim_reg) || (ncol >= dim_reg);

    assign ia = AW'(int'(row_reg) * MAX_SIDE + int'(col_reg));
    assign ib = AW'(int'(nrow) * MAX_SIDE + int'(ncol));

    always_comb begin
        if (cmd_i.rd_a) begin
            raddr = ia;
        end else if (cmd_i.rd_b) begin
            raddr = ib;
        end else begin
            raddr = idx_reg;
        end
    end

    assign wb_en = pipe_v_reg && (rdata_reg == lb_reg);

    always_ff @(posedge aclk) begin
        if (cmd_i.wipe_step) begin
            mem[idx_reg] <= idx_reg;
        end else if (wb_en) begin
            mem[pipe_addr_reg] <= la_reg;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg     <= DIM_W'(RST_DIM);
            count_reg   <= CNT_W'(RST_CNT);
            idx_reg     <= '0;
            pipe_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                dim_reg   <= dim_next;
                count_reg <= cfg_sq;
            end else if (cmd_i.count_init) begin
                count_reg <= dim_sq;
            end else if (cmd_i.merge && (count_reg != '0)) begin
                count_reg <= count_reg - 1'b1;
            end

            if (cmd_i.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd_i.wipe_step || cmd_i.walk_rd) begin
                idx_reg <= idx_reg + 1'b1;
            end

            pipe_v_reg <= cmd_i.walk_rd;

            if (cmd_i.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            action_reg <= s_action;
            row_reg    <= s_cell_row;
            col_reg    <= s_cell_col;
            dir_reg    <= s_direction;
        end
        if (cmd_i.lat_a) begin
            la_reg <= rdata_reg;
        end
        if (cmd_i.lat_b) begin
            lb_reg <= rdata_reg;
        end
        pipe_addr_reg <= idx_reg;
        if (cmd_i.flags_init) begin
            removed_reg <= 1'b0;
            bad_reg     <= (action_reg != ACT_CLEAR) && bad_comb;
        end else if (cmd_i.merge) begin
            removed_reg <= 1'b1;
        end
        if (cmd_i.out_load) begin
            m_wall_removed <= removed_reg;
            m_regions_left <= count_reg[OUT_CNT_W-1:0];
            m_all_joined   <= (count_reg == CNT_W'(1));
            m_bad_wall     <= bad_reg;
        end
    end

    assign m_valid = m_valid_reg;

    assign status_o.is_clear = (action_reg == ACT_CLEAR);
    assign status_o.bad      = bad_comb;
    assign status_o.same     = (rdata_reg == la_reg);
    assign status_o.idx_last = (idx_reg == AW'(CELLS - 1));
    assign status_o.out_free = !m_valid_reg || m_ready;

    ap_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dim_sq)
        else $error("Region count exceeds the number of cells in the grid.");

    ap_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.out_load |-> (!m_valid_reg || m_ready))
        else $error("Result loaded over an untaken result.");

    ap_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_wall_removed && m_bad_wall))
        else $error("A result reports both a removed wall and a bad wall.");

    ap_wb_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_en |-> (la_reg != lb_reg))
        else $error("Relabel write with identical source and target labels.");

endmodule

`default_nettype wire

// ----- hw/rtl/grid_region_union_merge.sv -----
// Top level of the grid region union merge block.
// The block keeps a region label for every cell of a square grid and merges
// regions as walls between neighboring cells are offered to it.
// Requests enter on the s_ channel (valid and ready) and each one yields exactly
// one result on the m_ channel (valid and ready), in request order.
// Every request passes a bounds check before any label access.
// A clear request relabels all MAX_SIDE*MAX_SIDE cells in one sweep.
// A wall request reads both cell labels through the states RD_A, RD_B and CMP;
// when the regions differ, a relabel sweep visits every cell once.
// The block is ready for the next request in the same cycle as a result appears.
// The single label memory port pair limits each sweep to one cell per cycle.
// Writing grid_dimension while idle clears the grid with the same sweep; no
// request is taken meanwhile; the sweep also runs after reset, at dimension 7.
// The result sits in an output register, so a stalled receiver holds only the
// next result; a new request is taken while an earlier result waits.
`default_nettype none

module grid_region_union_merge
    import grum_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_action,
    input  wire logic [ROW_W-1:0]     s_cell_row,
    input  wire logic [ROW_W-1:0]     s_cell_col,
    input  wire logic                 s_direction,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_wall_removed,
    output logic [OUT_CNT_W-1:0]      m_regions_left,
    output logic                      m_all_joined,
    output logic                      m_bad_wall,
    input  wire logic                 cfg_we,
    input  wire logic [DIM_W-1:0]     cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    grum_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .cfg_we   (cfg_we),
        .status_i (status),
        .cmd_o    (cmd)
    );

    grum_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_action       (s_action),
        .s_cell_row     (s_cell_row),
        .s_cell_col     (s_cell_col),
        .s_direction    (s_direction),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd_i          (cmd),
        .status_o       (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_wall_removed (m_wall_removed),
        .m_regions_left (m_regions_left),
        .m_all_joined   (m_all_joined),
        .m_bad_wall     (m_bad_wall)
    );

endmodule

`default_nettype wire

// ----- bench/region_merge_checker.sv -----
// Watches the request, result and configuration ports, predicts every result and compares it.
`timescale 1ns / 1ps

module region_merge_checker
    import grum_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic                 s_action,
    input  wire logic [ROW_W-1:0]     s_cell_row,
    input  wire logic [ROW_W-1:0]     s_cell_col,
    input  wire logic                 s_direction,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic                 m_wall_removed,
    input  wire logic [OUT_CNT_W-1:0] m_regions_left,
    input  wire logic                 m_all_joined,
    input  wire logic                 m_bad_wall,
    input  wire logic                 cfg_we,
    input  wire logic [DIM_W-1:0]     cfg_wdata,
    output int                        pending,
    output int                        errors
);

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;

    typedef struct packed {
        logic                 removed;
        logic [OUT_CNT_W-1:0] regions;
        logic                 joined;
        logic                 bad;
    } merge_result_t;

    int unsigned   cell_label [CELL_COUNT];
    int unsigned   region_total;
    int unsigned   side;
    merge_result_t expected_results [$];
    merge_result_t want;
    merge_result_t got;
    int            mismatches = 0;
    int            waiting = 0;

    assign pending = waiting;
    assign errors  = mismatches;

    function automatic void clear_regions();
        for (int i = 0; i < CELL_COUNT; i++) begin
            cell_label[i] = i;
        end
        region_total = side * side;
    endfunction

    function automatic int unsigned clamp_side(logic [DIM_W-1:0] value);
        if (value < DIM_MIN) begin
            return DIM_MIN;
        end
        if (value > GRID_SIDE) begin
            return GRID_SIDE;
        end
        return value;
    endfunction

    function automatic merge_result_t predict_merge(logic act, logic [ROW_W-1:0] row,
                                                    logic [ROW_W-1:0] col, logic dir);
        merge_result_t res;
        int unsigned   nrow;
        int unsigned   ncol;
        int unsigned   label_a;
        int unsigned   label_b;
        res = '0;
        if (act == ACT_CLEAR) begin
            clear_regions();
        end else begin
            nrow = row + ((dir == DIR_RIGHT) ? 0 : 1);
            ncol = col + ((dir == DIR_RIGHT) ? 1 : 0);
            if (row >= side || col >= side || nrow >= side || ncol >= side) begin
                res.bad = 1'b1;
            end else begin
                label_a = cell_label[row * GRID_SIDE + col];
                label_b = cell_label[nrow * GRID_SIDE + ncol];
                if (label_a != label_b) begin
                    for (int i = 0; i < CELL_COUNT; i++) begin
                        if (cell_label[i] == label_b) begin
                            cell_label[i] = label_a;
                        end
                    end
                    if (region_total > 0) begin
                        region_total--;
                    end
                    res.removed = 1'b1;
                end
            end
        end
        res.regions = region_total[OUT_CNT_W-1:0];
        res.joined  = (region_total == 1);
        return res;
    endfunction

    function automatic void report_field(string field, int expected_value, int actual_value);
        if (expected_value != actual_value) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, expected_value,
                     actual_value);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            side = clamp_side(DIM_RESET);
            clear_regions();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.removed = m_wall_removed;
                got.regions = m_regions_left;
                got.joined  = m_all_joined;
                got.bad     = m_bad_wall;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request outstanding, expected none actual %0d",
                             $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        report_field("wall_removed", want.removed, got.removed);
                        report_field("regions_left", want.regions, got.regions);
                        report_field("all_joined", want.joined, got.joined);
                        report_field("bad_wall", want.bad, got.bad);
                    end
                end
            end
            if (cfg_we) begin
                side = clamp_side(cfg_wdata);
                clear_regions();
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_merge(s_action, s_cell_row, s_cell_col,
                                                         s_direction));
            end
        end
        waiting <= expected_results.size();
    end

endmodule

// ----- bench/tb_grid_region_union_merge.sv -----
// Testbench top for the grid region union merge block: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_grid_region_union_merge;
    import grum_pkg::*;

    localparam int               GRID_SIDE = 64;
    localparam logic [ROW_W-1:0] ROW_MAX   = '1;
    localparam logic             ACT_WALL  = ~ACT_CLEAR;
    localparam logic             DIR_DOWN  = ~DIR_RIGHT;
    localparam int               NUM_PHASES = 5;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_action = ACT_CLEAR;
    logic [ROW_W-1:0]     s_cell_row = '0;
    logic [ROW_W-1:0]     s_cell_col = '0;
    logic                 s_direction = DIR_RIGHT;
    logic                 m_ready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [DIM_W-1:0]     cfg_wdata = '0;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_wall_removed;
    logic [OUT_CNT_W-1:0] m_regions_left;
    logic                 m_all_joined;
    logic                 m_bad_wall;
    int                   pending;
    int                   errors;
    int                   s_idle_pct = 33;
    int                   r_idle_pct = 81;

    int phase_cfg   [NUM_PHASES] = '{3, 1, 90, 10, 64};
    int phase_side  [NUM_PHASES] = '{3, 2, 64, 10, 64};
    int phase_s_idle[NUM_PHASES] = '{33, 81, 81, 0, 0};
    int phase_r_idle[NUM_PHASES] = '{81, 33, 33, 0, 0};
    int phase_items [NUM_PHASES] = '{30, 15, 20, 25, 26};

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= r_idle_pct);
    end

    grid_region_union_merge #(
        .MAX_SIDE(GRID_SIDE)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_cell_row    (s_cell_row),
        .s_cell_col    (s_cell_col),
        .s_direction   (s_direction),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_wall_removed(m_wall_removed),
        .m_regions_left(m_regions_left),
        .m_all_joined  (m_all_joined),
        .m_bad_wall    (m_bad_wall),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    region_merge_checker #(
        .GRID_SIDE(GRID_SIDE)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_cell_row    (s_cell_row),
        .s_cell_col    (s_cell_col),
        .s_direction   (s_direction),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_wall_removed(m_wall_removed),
        .m_regions_left(m_regions_left),
        .m_all_joined  (m_all_joined),
        .m_bad_wall    (m_bad_wall),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pending       (pending),
        .errors        (errors)
    );

    task automatic send_request(input logic act, input logic [ROW_W-1:0] row,
                                input logic [ROW_W-1:0] col, input logic dir);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_cell_row  <= row;
        s_cell_col  <= col;
        s_direction <= dir;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds off new requests until every outstanding result has been returned.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 || !s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_dimension(input logic [DIM_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Most walls land inside the grid so that regions actually merge.
    task automatic random_request(input int grid_side);
        logic             act;
        logic             dir;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        act = ($urandom_range(0, 39) == 0) ? ACT_CLEAR : ACT_WALL;
        if ($urandom_range(0, 9) < 8) begin
            row = ROW_W'($urandom_range(0, grid_side - 1));
            col = ROW_W'($urandom_range(0, grid_side - 1));
        end else begin
            row = ROW_W'($urandom_range(0, ROW_MAX));
            col = ROW_W'($urandom_range(0, ROW_MAX));
        end
        dir = $urandom_range(0, 1) ? DIR_DOWN : DIR_RIGHT;
        if ($urandom_range(0, 24) == 0) begin
            drain_results();
        end
        send_request(act, row, col, dir);
    endtask

    initial begin
        #10_000_000;
        $display("tb_grid_region_union_merge NOT OK");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(ACT_CLEAR, ROW_MAX, ROW_MAX, DIR_DOWN);
        send_request(ACT_WALL, 0, 0, DIR_RIGHT);
        send_request(ACT_WALL, 0, 0, DIR_RIGHT);
        send_request(ACT_WALL, 0, 1, DIR_DOWN);
        send_request(ACT_WALL, 1, 0, DIR_RIGHT);
        send_request(ACT_WALL, 0, 0, DIR_DOWN);
        send_request(ACT_WALL, 6, 6, DIR_RIGHT);
        send_request(ACT_WALL, 6, 6, DIR_DOWN);
        send_request(ACT_WALL, 5, 6, DIR_DOWN);
        send_request(ACT_WALL, 6, 5, DIR_RIGHT);
        send_request(ACT_WALL, ROW_MAX, ROW_MAX, DIR_DOWN);
        send_request(ACT_WALL, 7, 0, DIR_RIGHT);
        send_request(ACT_CLEAR, 0, 0, DIR_RIGHT);

        write_dimension(0);
        send_request(ACT_WALL, 0, 0, DIR_RIGHT);
        send_request(ACT_WALL, 0, 0, DIR_DOWN);
        send_request(ACT_WALL, 1, 0, DIR_RIGHT);
        send_request(ACT_WALL, 0, 1, DIR_DOWN);
        send_request(ACT_WALL, 1, 1, DIR_RIGHT);
        send_request(ACT_WALL, 0, 1, DIR_RIGHT);
        send_request(ACT_CLEAR, 0, 0, DIR_RIGHT);

        write_dimension(127);
        send_request(ACT_WALL, ROW_MAX, ROW_MAX - 1'b1, DIR_RIGHT);
        send_request(ACT_WALL, ROW_MAX - 1'b1, ROW_MAX, DIR_DOWN);
        send_request(ACT_WALL, ROW_MAX, ROW_MAX, DIR_RIGHT);
        send_request(ACT_WALL, ROW_MAX, 0, DIR_DOWN);

        for (int p = 0; p < NUM_PHASES; p++) begin
            s_idle_pct = phase_s_idle[p];
            r_idle_pct = phase_r_idle[p];
            write_dimension(DIM_W'(phase_cfg[p]));
            for (int n = 0; n < phase_items[p]; n++) begin
                random_request(phase_side[p]);
            end
        end

        drain_results();
        repeat (GRID_SIDE * GRID_SIDE + 100) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("tb_grid_region_union_merge OK");
        end else begin
            $display("tb_grid_region_union_merge NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/grum_pkg.sv
hw/rtl/grum_ctrl.sv
hw/rtl/grum_dp.sv
hw/rtl/grid_region_union_merge.sv
bench/region_merge_checker.sv
bench/tb_grid_region_union_merge.sv
